### hw/rtl/ssl_pkg.sv
// Shared types and constants for the subscription slot table.
// Request/result structs, command and status codes, scan state encoding.
// No dependencies.
package ssl_pkg;

  localparam int SLOTS       = 64;
  localparam int MAX_FILTERS = 16;

  localparam int SLOT_AW = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);

  // Fixed field widths of the ports
  localparam int REQ_W    = 2;
  localparam int CLIENT_W = 16;
  localparam int KEY_W    = 64;
  localparam int FREF_W   = 16;
  localparam int FCNT_W   = 5;
  localparam int STAT_W   = 3;
  localparam int SLOT_W   = 6;
  localparam int RCNT_W   = 7;
  localparam int ACNT_W   = 7;

  typedef enum logic [REQ_W-1:0] {
    OP_ADD        = 2'd0,
    OP_REMOVE     = 2'd1,
    OP_REMOVE_ALL = 2'd2,
    OP_FIND       = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_t;

  typedef struct packed {
    logic [REQ_W-1:0]    req_type;
    logic [CLIENT_W-1:0] client_id;
    logic [KEY_W-1:0]    sub_key;
    logic [FREF_W-1:0]   filter_ref;
    logic [FCNT_W-1:0]   filter_count;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [SLOT_W-1:0]   slot_index;
    logic [RCNT_W-1:0]   removed_count;
    logic [FREF_W-1:0]   found_filter_ref;
    logic [FCNT_W-1:0]   found_filter_count;
    logic [ACNT_W-1:0]   active_count;
  } rsp_t;

  // Classified command handed from front to back
  typedef struct packed {
    op_t                 op;
    logic [CLIENT_W-1:0] client;
    logic [KEY_W-1:0]    key;
    logic [FREF_W-1:0]   fref;
    logic [FCNT_W-1:0]   fcnt;
  } cmd_t;

  // One stored slot
  typedef struct packed {
    logic [CLIENT_W-1:0] client;
    logic [KEY_W-1:0]    key;
    logic [FREF_W-1:0]   fref;
    logic [FCNT_W-1:0]   fcnt;
  } entry_t;

  typedef struct packed {
    logic avail;
    cmd_t head;
  } queue_out_t;

endpackage

### hw/rtl/ssl_front.sv
// Front end: accepts requests, decodes the op, clamps the filter count,
// and buffers commands in a two-entry queue. Depends on ssl_pkg.
module ssl_front import ssl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  req_t       req,
  input  logic       pop,
  output queue_out_t q_out
);

  cmd_t       cmd_in;
  cmd_t       q_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       do_pop;

  always_comb begin
    cmd_in.client = req.client_id;
    cmd_in.key    = req.sub_key;
    cmd_in.fref   = req.filter_ref;
    if (int'(req.filter_count) > MAX_FILTERS) begin
      cmd_in.fcnt = FCNT_W'(MAX_FILTERS);
    end else begin
      cmd_in.fcnt = req.filter_count;
    end
    cmd_in.op = op_t'(req.req_type);
  end

  assign busy       = (count == 2'd2);
  assign push       = start && !busy;
  assign do_pop     = pop && (count != 2'd0);
  assign q_out.avail = (count != 2'd0);
  assign q_out.head  = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cmd_in;
    end
  end

endmodule

### hw/rtl/ssl_back.sv
// Back end: slot memory, valid bits and the scan engine that serves one
// command per pass over all slots. Depends on ssl_pkg.
module ssl_back import ssl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  queue_out_t q_out,
  output logic       pop,
  output logic       done,
  output rsp_t       result
);

  state_t              state;
  state_t              state_next;
  cmd_t                cmd;
  logic [CNT_W-1:0]    idx;
  logic                cmp_en;
  logic [SLOT_AW-1:0]  cmp_idx;
  entry_t              rd_data;
  logic [SLOTS-1:0]    valid;
  logic                hit;
  logic [SLOT_AW-1:0]  hit_idx;
  logic [FREF_W-1:0]   hit_fref;
  logic [FCNT_W-1:0]   hit_fcnt;
  logic                free_found;
  logic [SLOT_AW-1:0]  free_idx;
  logic [CNT_W-1:0]    removed;
  logic [CNT_W-1:0]    live;

  entry_t              mem [SLOTS];

  logic                scan_last;
  logic                slot_live;
  logic                client_eq;
  logic                key_match;
  logic                mem_we;
  logic [SLOT_AW-1:0]  mem_waddr;
  entry_t              mem_wdata;
  logic                set_en;
  logic                clr_en;
  logic [SLOT_AW-1:0]  clr_idx;
  logic [CNT_W-1:0]    live_next;
  rsp_t                rsp_next;

  assign scan_last = (idx == CNT_W'(SLOTS));
  assign slot_live = valid[cmp_idx];
  assign client_eq = (rd_data.client == cmd.client);
  assign key_match = slot_live && client_eq && (rd_data.key == cmd.key);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (q_out.avail) state_next = S_SCAN;
      S_SCAN:  if (scan_last) state_next = S_APPLY;
      S_APPLY: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = hit_idx;
    mem_wdata = '{client: cmd.client, key: cmd.key, fref: cmd.fref, fcnt: cmd.fcnt};
    set_en    = 1'b0;
    clr_en    = 1'b0;
    clr_idx   = cmp_idx;
    live_next = live;
    rsp_next  = '0;
    case (state)
      S_IDLE: begin
        pop = q_out.avail;
      end
      S_SCAN: begin
        // remove-all clears matching clients as the scan passes them
        if (cmp_en && cmd.op == OP_REMOVE_ALL && slot_live && client_eq) begin
          clr_en    = 1'b1;
          live_next = live - CNT_W'(1);
        end
      end
      S_APPLY: begin
        rsp_next.status = ST_NOT_FOUND;
        case (cmd.op)
          OP_ADD: begin
            if (hit) begin
              mem_we               = 1'b1;
              rsp_next.status      = ST_UPDATED;
              rsp_next.slot_index  = SLOT_W'(hit_idx);
            end else if (free_found) begin
              mem_we               = 1'b1;
              mem_waddr            = free_idx;
              set_en               = 1'b1;
              live_next            = live + CNT_W'(1);
              rsp_next.status      = ST_INSERTED;
              rsp_next.slot_index  = SLOT_W'(free_idx);
            end else begin
              rsp_next.status      = ST_FULL;
            end
          end
          OP_REMOVE: begin
            if (hit) begin
              clr_en               = 1'b1;
              clr_idx              = hit_idx;
              live_next            = live - CNT_W'(1);
              rsp_next.status      = ST_REMOVED;
              rsp_next.slot_index  = SLOT_W'(hit_idx);
            end
          end
          OP_REMOVE_ALL: begin
            rsp_next.removed_count = RCNT_W'(removed);
            if (removed != '0) begin
              rsp_next.status      = ST_REMOVED;
            end
          end
          default: begin
            if (hit) begin
              rsp_next.status             = ST_FOUND;
              rsp_next.slot_index         = SLOT_W'(hit_idx);
              rsp_next.found_filter_ref   = hit_fref;
              rsp_next.found_filter_count = hit_fcnt;
            end
          end
        endcase
        rsp_next.active_count = ACNT_W'(live_next);
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      valid  <= '0;
      live   <= '0;
      done   <= 1'b0;
      cmp_en <= 1'b0;
    end else begin
      state <= state_next;
      live  <= live_next;
      done  <= (state == S_APPLY);
      if (set_en) begin
        valid[mem_waddr] <= 1'b1;
      end
      if (clr_en) begin
        valid[clr_idx] <= 1'b0;
      end
      if (state == S_SCAN) begin
        cmp_en <= !scan_last;
      end else begin
        cmp_en <= 1'b0;
      end
    end
  end

  // Scan bookkeeping; the compare stage works on the read address of the cycle before
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd        <= q_out.head;
      idx        <= '0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      removed    <= '0;
    end else if (state == S_SCAN) begin
      cmp_idx <= idx[SLOT_AW-1:0];
      if (!scan_last) begin
        idx <= idx + CNT_W'(1);
      end
      if (cmp_en) begin
        if (key_match && !hit) begin
          hit      <= 1'b1;
          hit_idx  <= cmp_idx;
          hit_fref <= rd_data.fref;
          hit_fcnt <= rd_data.fcnt;
        end
        if (!slot_live && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= cmp_idx;
        end
        if (clr_en) begin
          removed <= removed + CNT_W'(1);
        end
      end
    end
    if (state == S_APPLY) begin
      result <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[idx[SLOT_AW-1:0]];
  end

  a_live_tracks_valid: assert property (@(posedge clk) disable iff (rst)
    CNT_W'($countones(valid)) == live)
    else $error("active count differs from number of valid slots");

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live <= CNT_W'(SLOTS))
    else $error("active count above table size");

  a_done_after_apply: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_APPLY))
    else $error("result strobe without a finished scan");

  a_cmp_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmp_en |-> state == S_SCAN)
    else $error("compare stage active outside a scan");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> state == S_SCAN && idx == '0)
    else $error("command popped without starting a scan");

endmodule

### hw/rtl/subscription_slot_table.sv
// Top level of the subscription slot table: front queue plus scan engine.
// Depends on ssl_pkg, ssl_front, ssl_back.
//
//   channel   ports                     handshake
//   request   start, busy, req (req_t)  taken when start && !busy
//   result    done, result (rsp_t)      valid for the one cycle done is high
//
// In the back end each request goes through a pop, one pass of the slot
// memory's single read port over all SLOTS entries with one compare stage,
// and an apply step; then done pulses for one cycle.
// Two requests can wait in the front queue; busy rises when it is full.
// Synchronous reset empties the queue and clears all valid bits at once.
// Results cannot be stalled.
module subscription_slot_table import ssl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t result
);

  queue_out_t q_out;
  logic       pop;

  ssl_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .pop   (pop),
    .q_out (q_out)
  );

  ssl_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_out  (q_out),
    .pop    (pop),
    .done   (done),
    .result (result)
  );

endmodule
